[rtl/dna_base_packer_macros.svh]
// Assertion macros shared by the packer RTL.
`ifndef DNA_BASE_PACKER_MACROS_SVH
`define DNA_BASE_PACKER_MACROS_SVH
`ifndef ASSERT_OFF
// Check on every clock edge outside reset.
`define DBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check on every clock edge, reset included.
`define DBP_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DBP_ASSERT(lbl, prop, msg)
`define DBP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[rtl/dbp_pkg.sv]
// Package: pack modes and letter code tables for the DNA base packer.
`timescale 1ns / 1ps
`default_nettype none
package dbp_pkg;

	typedef logic [1:0] mode_t;
	typedef logic [1:0] fill_t;

	localparam mode_t MODE_IUPAC  = 2'd0;
	localparam mode_t MODE_NIBBLE = 2'd1;
	localparam mode_t MODE_BASE2  = 2'd2;

	// Fold lower case letters onto upper case.
	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		if (c >= "a" && c <= "z") begin
			return c - 8'd32;
		end
		return c;
	endfunction

	// 4-bit IUPAC code; anything outside the table maps to zero.
	function automatic logic [3:0] iupac_code(input logic [7:0] c);
		logic [3:0] code;
		unique case (fold_upper(c))
			"A": code = 4'd1;
			"C": code = 4'd2;
			"M": code = 4'd3;
			"G": code = 4'd4;
			"R": code = 4'd5;
			"S": code = 4'd6;
			"V": code = 4'd7;
			"T": code = 4'd8;
			"W": code = 4'd9;
			"Y": code = 4'd10;
			"H": code = 4'd11;
			"K": code = 4'd12;
			"D": code = 4'd13;
			"B": code = 4'd14;
			default: code = 4'd0;
		endcase
		return code;
	endfunction

	// 2-bit base code; A and every other letter map to zero.
	function automatic logic [1:0] base2_code(input logic [7:0] c);
		logic [1:0] code;
		unique case (fold_upper(c))
			"C": code = 2'd1;
			"G": code = 2'd2;
			"T": code = 2'd3;
			default: code = 2'd0;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

[rtl/dbp_in_if.sv]
// Interface: letter request channel (ASCII letter plus last flag).
`timescale 1ns / 1ps
`default_nettype none
interface dbp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] base_char;
	logic       last_in;

	modport source (output valid, output base_char, output last_in, input ready);
	modport sink (input valid, input base_char, input last_in, output ready);
endinterface
`default_nettype wire

[rtl/dbp_out_if.sv]
// Interface: packed byte request channel (byte plus last flag).
`timescale 1ns / 1ps
`default_nettype none
interface dbp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] packed_byte;
	logic       last_out;

	modport source (output valid, output packed_byte, output last_out, input ready);
	modport sink (input valid, input packed_byte, input last_out, output ready);
endinterface
`default_nettype wire

[rtl/dna_base_packer.sv]
// DNA base packer: ASCII nucleotide letters in, IUPAC or 2-bit packed bytes out.
//
// Channels: "letter" takes one ASCII letter per request with a last flag;
// "coded" returns encoded bytes with a last flag. Both are valid/ready.
// cfg_we/cfg_wdata write pack_mode (0 one IUPAC code per byte, 1 two IUPAC
// nibbles per byte, 2 four 2-bit bases per byte, 3 acts as 0). A mode write
// also drops any partly filled byte; write it only while the block is idle.
//
// Throughput: one letter per cycle while coded is not held off, set by the
// single encode-and-merge step between the input register and the output register.
// Path: an accepted letter is registered in the input register; once the output
// register is free, the byte it completes is registered in the output register
// and is valid on the coded channel. Modes 1 and 2 emit one byte per two or
// four letters; a last letter flushes a partial byte padded with zeros and
// marked last.
// Stall: while coded is held off, the output register keeps its byte, the
// input register holds one more letter, and letter.ready drops after that.
// Reset: arst_n clears both stage valids, the mode (to 0) and the partial byte.
`timescale 1ns / 1ps
`default_nettype none
`include "dna_base_packer_macros.svh"
module dna_base_packer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	dbp_in_if.sink             letter,
	dbp_out_if.source          coded,
	input  wire logic          cfg_we,
	input  wire dbp_pkg::mode_t cfg_wdata
);
	import dbp_pkg::*;

	// Configuration and packing state.
	mode_t      mode_q;
	logic [7:0] partial_q;
	fill_t      fill_q;

	// Input stage: one accepted letter.
	logic       v_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// Output stage: one finished byte.
	logic       v_s2;
	logic [7:0] byte_s2;
	logic       last_s2;

	logic       s2_free;
	logic       adv_s1;
	logic       in_acc;

	logic [3:0] nib;
	logic [1:0] b2;
	logic [7:0] merged;
	logic       emit;
	logic [7:0] emit_byte;
	logic [7:0] partial_d;
	fill_t      fill_d;

	// The output register frees up when empty or when its byte is taken.
	assign s2_free = !v_s2 || coded.ready;
	assign adv_s1  = v_s1 && s2_free;
	assign letter.ready = !v_s1 || s2_free;
	assign in_acc  = letter.valid && letter.ready;

	assign coded.valid       = v_s2;
	assign coded.packed_byte = byte_s2;
	assign coded.last_out    = last_s2;

	// Encode the held letter and merge it into the partial byte.
	always_comb begin
		nib = iupac_code(char_s1);
		b2  = base2_code(char_s1);
		// Place the 2-bit code at the slot for the current fill level.
		case (fill_q)
			2'd0: merged = partial_q | {b2, 6'b0};
			2'd1: merged = partial_q | {2'b0, b2, 4'b0};
			2'd2: merged = partial_q | {4'b0, b2, 2'b0};
			default: merged = partial_q | {6'b0, b2};
		endcase
		emit      = 1'b1;
		emit_byte = {4'b0, nib};
		partial_d = partial_q;
		fill_d    = fill_q;
		unique case (mode_q)
			MODE_NIBBLE: begin
				if (fill_q == 2'd0) begin
					// First nibble goes high; flush it alone on a last letter.
					emit_byte = {nib, 4'b0};
					emit      = last_s1;
					partial_d = last_s1 ? 8'd0 : {nib, 4'b0};
					fill_d    = last_s1 ? 2'd0 : 2'd1;
				end else begin
					emit_byte = {partial_q[7:4], nib};
					partial_d = 8'd0;
					fill_d    = 2'd0;
				end
			end
			MODE_BASE2: begin
				emit      = (fill_q == 2'd3) || last_s1;
				emit_byte = merged;
				partial_d = emit ? 8'd0 : merged;
				fill_d    = emit ? 2'd0 : fill_q + 2'd1;
			end
			default: begin
				// One IUPAC code per byte; partial state stays untouched.
				emit      = 1'b1;
				emit_byte = {4'b0, nib};
			end
		endcase
	end

	// Control: stage valids, mode and packing state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			mode_q    <= MODE_IUPAC;
			partial_q <= 8'd0;
			fill_q    <= 2'd0;
		end else begin
			if (letter.ready) begin
				v_s1 <= letter.valid;
			end
			if (s2_free) begin
				v_s2 <= adv_s1 && emit;
			end
			if (cfg_we) begin
				// New mode: drop whatever partial byte was gathered.
				mode_q    <= cfg_wdata;
				partial_q <= 8'd0;
				fill_q    <= 2'd0;
			end else if (adv_s1) begin
				partial_q <= partial_d;
				fill_q    <= fill_d;
			end
		end
	end

	// Payload: capture the letter, then the finished byte.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			char_s1 <= letter.base_char;
			last_s1 <= letter.last_in;
		end
		if (adv_s1 && emit) begin
			byte_s2 <= emit_byte;
			last_s2 <= last_s1;
		end
	end

	`DBP_ASSERT_RST(a_reset_empty, (!arst_n) |=> (!v_s1 && !v_s2), "stage valid set in reset")
	`DBP_ASSERT(a_iupac_no_fill, ((mode_q == MODE_IUPAC) || (mode_q == 2'd3)) |-> (fill_q == 2'd0), "fill count in IUPAC mode")
	`DBP_ASSERT(a_nibble_fill, (mode_q == MODE_NIBBLE) |-> (fill_q <= 2'd1), "nibble mode fill above one")
	`DBP_ASSERT(a_last_flushes, (adv_s1 && last_s1) |=> (fill_q == 2'd0), "partial byte kept after last letter")
	`DBP_ASSERT(a_base2_low_clear, ((mode_q == MODE_BASE2) && (fill_q == 2'd1)) |-> (partial_q[5:0] == 6'd0), "unfilled slots not zero")

endmodule
`default_nettype wire

[tb/dbp_pack_checker.sv]
// Checker for the DNA base packer: predicts packed bytes from observed letters and compares.
`timescale 1ns / 1ps
module dbp_pack_checker (
	input  logic           clk,
	input  logic           arst_n,
	dbp_in_if              letter_mon,
	dbp_out_if             packed_mon,
	input  logic           cfg_we,
	input  dbp_pkg::mode_t cfg_wdata,
	output int             fail_count,
	output int             pending_count
);
	import dbp_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_result_t;

	byte_result_t expected_bytes [$];
	mode_t        pack_mode_q;
	logic [7:0]   gather;
	fill_t        held;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
	endfunction

	function automatic logic [3:0] iupac_nibble(input logic [7:0] c);
		case (to_upper(c))
			"A": return 4'd1;
			"C": return 4'd2;
			"M": return 4'd3;
			"G": return 4'd4;
			"R": return 4'd5;
			"S": return 4'd6;
			"V": return 4'd7;
			"T": return 4'd8;
			"W": return 4'd9;
			"Y": return 4'd10;
			"H": return 4'd11;
			"K": return 4'd12;
			"D": return 4'd13;
			"B": return 4'd14;
			default: return 4'd0;
		endcase
	endfunction

	// A and every ambiguity letter share code zero
	function automatic logic [1:0] two_bit_code(input logic [7:0] c);
		case (to_upper(c))
			"C": return 2'd1;
			"G": return 2'd2;
			"T": return 2'd3;
			default: return 2'd0;
		endcase
	endfunction

	task automatic predict_letter(input logic [7:0] c, input logic last_flag);
		byte_result_t r;
		logic         emit;
		emit = 1'b1;
		case (pack_mode_q)
			MODE_NIBBLE: begin
				if (held == 2'd0) begin
					gather = {iupac_nibble(c), 4'h0};
					held = 2'd1;
					emit = last_flag;
				end else begin
					gather = gather | {4'h0, iupac_nibble(c)};
				end
			end
			MODE_BASE2: begin
				gather[6 - 2 * held +: 2] = two_bit_code(c);
				held = held + 2'd1;
				emit = (held == 2'd0) || last_flag;
			end
			default: gather = {4'h0, iupac_nibble(c)};
		endcase
		if (emit) begin
			r.data = gather;
			r.last = last_flag;
			expected_bytes.push_back(r);
			gather = '0;
			held = '0;
		end
	endtask

	task automatic check_result(input logic [7:0] got_byte, input logic got_last);
		byte_result_t want;
		if (expected_bytes.size() == 0) begin
			fail_count++;
			$display("%0t: packed byte with none expected, actual %02h last %0b",
				$time, got_byte, got_last);
			return;
		end
		want = expected_bytes.pop_front();
		if (got_byte !== want.data) begin
			fail_count++;
			$display("%0t: packed_byte expected %02h actual %02h", $time, want.data, got_byte);
		end
		if (got_last !== want.last) begin
			fail_count++;
			$display("%0t: last_out expected %0b actual %0b", $time, want.last, got_last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_mode_q = MODE_IUPAC;
			gather = '0;
			held = '0;
			expected_bytes.delete();
			pending_count <= 0;
		end else begin
			if (packed_mon.valid && packed_mon.ready) begin
				check_result(packed_mon.packed_byte, packed_mon.last_out);
			end
			// a mode write drops any partial byte
			if (cfg_we) begin
				pack_mode_q = cfg_wdata;
				gather = '0;
				held = '0;
			end
			if (letter_mon.valid && letter_mon.ready) begin
				predict_letter(letter_mon.base_char, letter_mon.last_in);
			end
			pending_count <= expected_bytes.size();
		end
	end

endmodule

[tb/tb_dna_base_packer.sv]
// Testbench top for the DNA base packer: clock, reset, letter stimulus and verdict.
`timescale 1ns / 1ps
module tb_dna_base_packer;
	import dbp_pkg::*;

	// unused encoding; the block treats it like one IUPAC code per byte
	localparam mode_t MODE_SPARE = 2'd3;
	localparam int SEGMENT_LETTERS = 80;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cfg_we;
	mode_t cfg_wdata;
	int    fail_count;
	int    pending;
	int    send_idle_pct = 0;
	int    recv_idle_pct = 0;

	// letters the random part draws from; the first four are the 2-bit bases
	string iupac_letters = "ACGTNMRSVWYHKDBU";
	mode_t mode_plan [4] = '{MODE_BASE2, MODE_NIBBLE, MODE_SPARE, MODE_IUPAC};

	dbp_in_if  letter_ch ();
	dbp_out_if packed_ch ();

	// ports in declaration order: clk, arst_n, letter, coded, cfg_we, cfg_wdata
	dna_base_packer DUT (clk, arst_n, letter_ch, packed_ch, cfg_we, cfg_wdata);

	dbp_pack_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.letter_mon    (letter_ch),
		.packed_mon    (packed_ch),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending_count (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 0;
	end

	// Receiver: drop ready at random, at the rate of the current idle profile.
	initial begin
		packed_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			packed_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Hard stop in case the block hangs; far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("dna_base_packer regression: fail");
		$finish;
	end

	// Offer one letter request and hold it until the block takes it.
	// Call right after a rising edge; returns at the edge of acceptance.
	task automatic send_letter(input logic [7:0] c, input logic last_flag);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			letter_ch.valid <= 1'b0;
			@(posedge clk);
		end
		letter_ch.valid     <= 1'b1;
		letter_ch.base_char <= c;
		letter_ch.last_in   <= last_flag;
		do @(posedge clk); while (!letter_ch.ready);
	endtask

	// Send a string of letters, flagging the final one as last if asked.
	task automatic send_text(input string s, input logic last_at_end);
		for (int i = 0; i < s.len(); i++) begin
			send_letter(s[i], last_at_end && (i == s.len() - 1));
		end
	endtask

	// Stop sending, wait for every expected byte, then let the pipeline settle
	// so a letter that produced no byte is out of the block before a mode write.
	task automatic drain();
		letter_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// One-cycle register write; only called while the block is idle.
	task automatic write_mode(input mode_t m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Random letters: mostly valid nucleotide letters in either case, the rest
	// arbitrary bytes. Sequences end at random; the segment closes with a last.
	task automatic send_random(input int count, input mode_t m);
		logic [7:0] c;
		logic       last_flag;
		int         pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				// bias toward A/C/G/T in 2-bit mode so whole bytes get built
				if (m == MODE_BASE2 && pick < 6) begin
					c = iupac_letters[$urandom_range(0, 3)];
				end else begin
					c = iupac_letters[$urandom_range(0, 15)];
				end
				if ($urandom_range(0, 1)) begin
					c = c | 8'h20;
				end
			end else begin
				c = 8'($urandom_range(0, 255));
			end
			last_flag = (i == count - 1) || ($urandom_range(0, 7) == 0);
			send_letter(c, last_flag);
		end
	endtask

	initial begin
		letter_ch.valid     <= 1'b0;
		letter_ch.base_char <= 8'h00;
		letter_ch.last_in   <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= MODE_IUPAC;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One code per byte: byte extremes, mixed case, a letter outside the table.
		write_mode(MODE_IUPAC);
		send_letter(8'h00, 1'b0);
		send_letter(8'hFF, 1'b1);
		send_text("aTu", 1'b0);
		drain();

		// Two nibbles per byte: a flushed half byte, then last on a full byte.
		write_mode(MODE_NIBBLE);
		send_text("aCG", 1'b1);
		send_text("Tk", 1'b1);
		drain();

		// Four bases per byte: a full byte, then a padded partial byte.
		write_mode(MODE_BASE2);
		send_text("AcGt", 1'b0);
		send_text("Tg", 1'b1);
		drain();

		// Unused mode behaves like one code per byte.
		write_mode(MODE_SPARE);
		send_text("Bd", 1'b1);
		drain();

		// Leave a half byte behind, then drop it with a mode write; the next
		// byte must start clean. N packs like A and last lands on a full byte.
		write_mode(MODE_NIBBLE);
		send_text("A", 1'b0);
		drain();
		write_mode(MODE_BASE2);
		send_text("CGTN", 1'b1);
		drain();

		// Random part: three idle profiles, each walking every mode.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 38;
					recv_idle_pct = 86;
				end
				1: begin
					send_idle_pct = 86;
					recv_idle_pct = 38;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < 4; k++) begin
				write_mode(mode_plan[k]);
				send_random(SEGMENT_LETTERS, mode_plan[k]);
				drain();
			end
		end

		if (fail_count == 0 && pending == 0) begin
			$display("dna_base_packer regression: pass");
		end else begin
			$display("dna_base_packer regression: fail");
		end
		$finish;
	end

endmodule
